// File: src/u8d_pkg.sv
// shared types, constants and helpers for the utf-8 stream decoder
package u8d_pkg;

    // input beat payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } u8d_in_t;

    // result beat payload
    typedef struct packed {
        logic [31:0] code_point;
        logic        valid_res;
        logic [2:0]  bytes_used;
        logic        run_last;
        logic        final_result;
    } u8d_out_t;

    // controller to datapath
    typedef struct packed {
        logic append;
        logic emit;
    } u8d_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic decided;
        logic last;
    } u8d_status_t;

    localparam logic [31:0] ERR_RESET   = 32'h0000_FFFD;
    localparam logic [2:0]  WIN_DEPTH   = 3'd4;
    localparam logic [2:0]  LEN_BAD     = 3'd0;
    localparam logic [2:0]  LEN_ONE     = 3'd1;
    localparam logic [10:0] MIN_TWO     = 11'h080;
    localparam logic [15:0] MIN_THREE   = 16'h0800;
    localparam logic [15:0] SURR_LO     = 16'hD800;
    localparam logic [15:0] SURR_HI     = 16'hDFFF;
    localparam logic [20:0] MIN_FOUR    = 21'h10000;
    localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [1:0]  CONT_TAG    = 2'b10;

    // sequence length from the lead byte, zero when the lead is invalid
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end else begin
            len = LEN_BAD;
        end
        return len;
    endfunction

endpackage

// File: src/u8d_ctrl.sv
// controller: sequences byte intake and result emission
module u8d_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  u8d_pkg::u8d_status_t status,
    output u8d_pkg::u8d_cmd_t    cmd
);
    import u8d_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // handshake and commands
    assign s_ready    = (state_reg == ST_IDLE);
    assign out_free   = !m_valid_reg || m_ready;
    assign cmd.append = s_valid && s_ready;
    assign cmd.emit   = (state_reg == ST_RUN) && status.decided && out_free;
    assign m_valid    = m_valid_reg;

    // next state
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd.append) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!status.decided) begin
                    state_next = ST_IDLE;
                end else if (cmd.emit && status.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: src/u8d_datapath.sv
// datapath: byte window, sequence check and result register
module u8d_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  u8d_pkg::u8d_in_t     s_data,
    input  logic                 cfg_valid,
    input  logic [31:0]          cfg_data,
    input  u8d_pkg::u8d_cmd_t    cmd,
    output u8d_pkg::u8d_status_t status,
    output u8d_pkg::u8d_out_t    m_data
);
    import u8d_pkg::*;

    logic [7:0]  win_reg [4];
    logic [7:0]  win_next [4];
    logic [2:0]  cnt_reg, cnt_next;
    logic        end_reg;
    logic [31:0] err_reg;
    u8d_out_t    out_reg;

    logic [2:0]  len, used, rem, len_rem;
    logic        cont_ok, range_ok, ok;
    logic [10:0] v2;
    logic [15:0] v3;
    logic [20:0] v4;
    logic [31:0] cp;
    logic [2:0]  src;

    // lead length and continuation tags
    assign len     = lead_len(win_reg[0]);
    assign cont_ok = (len < 3'd2 || win_reg[1][7:6] == CONT_TAG)
                  && (len < 3'd3 || win_reg[2][7:6] == CONT_TAG)
                  && (len < 3'd4 || win_reg[3][7:6] == CONT_TAG);

    // assembled values per length
    assign v2 = {win_reg[0][4:0], win_reg[1][5:0]};
    assign v3 = {win_reg[0][3:0], win_reg[1][5:0], win_reg[2][5:0]};
    assign v4 = {win_reg[0][2:0], win_reg[1][5:0], win_reg[2][5:0], win_reg[3][5:0]};

    // overlong, surrogate and range checks
    always_comb begin
        case (len)
            3'd2:    range_ok = (v2 >= MIN_TWO);
            3'd3:    range_ok = (v3 >= MIN_THREE) && !(v3 >= SURR_LO && v3 <= SURR_HI);
            3'd4:    range_ok = (v4 >= MIN_FOUR) && (v4 <= MAX_SCALAR);
            default: range_ok = 1'b1;
        endcase
    end

    // decision for the window head
    always_comb begin
        ok = 1'b0;
        cp = err_reg;
        if (len == LEN_ONE) begin
            ok = 1'b1;
            cp = {24'd0, win_reg[0]};
        end else if (len != LEN_BAD && cnt_reg >= len && cont_ok && range_ok) begin
            ok = 1'b1;
            case (len)
                3'd2:    cp = {21'd0, v2};
                3'd3:    cp = {16'd0, v3};
                default: cp = {11'd0, v4};
            endcase
        end
    end

    assign used           = ok ? len : LEN_ONE;
    assign status.decided = (cnt_reg != 3'd0)
                         && (len == LEN_BAD || len == LEN_ONE || cnt_reg >= len || end_reg);

    // is the next head still waiting for bytes
    assign rem         = (used > cnt_reg) ? 3'd0 : cnt_reg - used;
    assign len_rem     = lead_len(win_reg[used[1:0]]);
    assign status.last = (rem == 3'd0)
                      || (!end_reg && len_rem != LEN_BAD && len_rem != LEN_ONE && rem < len_rem);

    // window update: append a byte or drop the consumed head
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            win_next[i] = win_reg[i];
        end
        cnt_next = cnt_reg;
        src      = 3'd0;
        if (cmd.append) begin
            if (cnt_reg < WIN_DEPTH) begin
                win_next[cnt_reg[1:0]] = s_data.data_byte;
                cnt_next               = cnt_reg + 3'd1;
            end
        end else if (cmd.emit) begin
            for (int i = 0; i < 4; i++) begin
                src = 3'(i) + used;
                if (src < WIN_DEPTH) begin
                    win_next[i] = win_reg[src[1:0]];
                end
            end
            cnt_next = rem;
        end
    end

    // window contents
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

    // window count, end flag and error value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
            end_reg <= 1'b0;
            err_reg <= ERR_RESET;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.append) begin
                end_reg <= s_data.stream_end;
            end
            if (cfg_valid) begin
                err_reg <= cfg_data;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.code_point   <= cp;
            out_reg.valid_res    <= ok;
            out_reg.bytes_used   <= used;
            out_reg.run_last     <= status.last;
            out_reg.final_result <= status.last && end_reg;
        end
    end

    assign m_data = out_reg;

endmodule

// File: src/utf8_stream_decoder_top.sv
// top level of the utf-8 stream decoder
//
// Input channel s_: one UTF-8 byte per beat, with a stream_end flag on the
// last byte of a stream. Result channel m_: one decoded code point per beat,
// or the error value with valid_res low, plus bytes_used, run_last (last
// result caused by an input beat) and final_result (last result of a stream).
// Config channel cfg_: writes the error value; always ready. The user must
// see that it is written only while idle; the block does not enforce this.
// Flow: a byte is first appended to the window; the datapath then decides
// its results one at a time over the four-byte window, and each is
// registered into the output register with m_valid once that register is
// free. Error retries and the end-of-stream flush add further results from
// the same beat. Reset clears the window, drops any pending result and
// restores the error value to 0xFFFD. When the receiver stalls, the result
// stays in the output register and decoding holds; input is accepted again
// once every result released by the previous beat has been issued, so no
// new byte is taken while the last one is still being decoded.
module utf8_stream_decoder_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  u8d_pkg::u8d_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output u8d_pkg::u8d_out_t  m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    import u8d_pkg::*;

    u8d_cmd_t    cmd;
    u8d_status_t status;

    assign cfg_ready = 1'b1;

    // control
    u8d_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // window and decode
    u8d_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

    // an accepted beat is followed by decoding before input is ready again
    a_intake_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on back-to-back cycles");

    // an error result always consumes exactly one byte
    a_err_one_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res |-> m_data.bytes_used == 3'd1)
        else $error("error result consumed more than one byte");

    // bytes_used stays within one to four
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.bytes_used != 3'd0 && m_data.bytes_used <= 3'd4)
        else $error("bytes_used out of range");

    // the stream's last result closes its beat's run
    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.final_result |-> m_data.run_last)
        else $error("final result without run_last");

endmodule

// File: sim/tb.sv
// testbench for the utf-8 stream decoder: directed and random streams against a predictor
module tb;
    import u8d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] ERR_AT_RESET = 32'h0000_FFFD;
    localparam logic [1:0]  CONT_BITS    = 2'b10;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          PRINT_CAP    = 60;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    u8d_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    u8d_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    // predictor state
    logic [7:0]  win_byte [4];
    int          win_fill = 0;
    logic [31:0] err_word = ERR_AT_RESET;
    u8d_out_t    cp_expected [$];

    int          mismatches = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    bit          s_held = 1'b0;

    utf8_stream_decoder_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // sequence length from a lead byte, zero for a byte that cannot lead
    function automatic int seq_length(input logic [7:0] b);
        if (b[7] == 1'b0) return 1;
        if (b[7:5] == 3'b110) return 2;
        if (b[7:4] == 4'b1110) return 3;
        if (b[7:3] == 5'b11110) return 4;
        return 0;
    endfunction

    // decide the head of the window; returns 0 while more bytes are needed
    function automatic bit decide_head(input bit at_end, output logic [31:0] cp,
                                       output int used, output bit ok);
        int          len;
        int          i;
        logic [20:0] v;
        len  = seq_length(win_byte[0]);
        ok   = 1'b0;
        used = 1;
        cp   = err_word;
        if (len == 1) begin
            cp = {24'd0, win_byte[0]};
            ok = 1'b1;
            return 1'b1;
        end
        if (len == 0) return 1'b1;
        if (win_fill < len) return at_end;
        for (i = 1; i < len; i++) begin
            if (win_byte[i][7:6] != CONT_BITS) return 1'b1;
        end
        case (len)
            2: begin
                v = {10'd0, win_byte[0][4:0], win_byte[1][5:0]};
                if (v < 21'h80) return 1'b1;
            end
            3: begin
                v = {5'd0, win_byte[0][3:0], win_byte[1][5:0], win_byte[2][5:0]};
                if (v < 21'h800 || (v >= 21'hD800 && v <= 21'hDFFF)) return 1'b1;
            end
            default: begin
                v = {win_byte[0][2:0], win_byte[1][5:0], win_byte[2][5:0], win_byte[3][5:0]};
                if (v < 21'h10000 || v > 21'h10FFFF) return 1'b1;
            end
        endcase
        cp   = {11'd0, v};
        used = len;
        ok   = 1'b1;
        return 1'b1;
    endfunction

    // append one byte to the window and queue every code point it releases
    function automatic void decode_byte(input logic [7:0] b, input bit at_end);
        u8d_out_t    res [4];
        int          n_res;
        int          used;
        int          i;
        logic [31:0] cp;
        bit          ok;
        n_res = 0;
        if (win_fill < 4) begin
            win_byte[win_fill] = b;
            win_fill++;
        end
        while (win_fill > 0 && n_res < 4) begin
            if (!decide_head(at_end, cp, used, ok)) break;
            res[n_res].code_point   = cp;
            res[n_res].valid_res    = ok;
            res[n_res].bytes_used   = 3'(used);
            res[n_res].run_last     = 1'b0;
            res[n_res].final_result = 1'b0;
            n_res++;
            if (used > win_fill) used = win_fill;
            for (i = 0; i + used < win_fill; i++) begin
                win_byte[i] = win_byte[i + used];
            end
            win_fill -= used;
        end
        if (at_end) win_fill = 0;
        if (n_res > 0) begin
            res[n_res - 1].run_last     = 1'b1;
            res[n_res - 1].final_result = at_end;
        end
        for (i = 0; i < n_res; i++) begin
            cp_expected.push_back(res[i]);
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("tb: mismatch on %s: got %h, want %h", what, got, want);
        end
    endtask

    // send one input beat after a random gap
    task automatic send_beat(input u8d_in_t beat);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            if (s_held) begin
                s_valid <= 1'b0;
                s_held = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        s_held = 1'b1;
        decode_byte(beat.data_byte, beat.stream_end);
    endtask

    // drop valid, wait for every pending code point, then let the block settle
    task automatic wait_idle;
        if (s_held) begin
            s_valid <= 1'b0;
            s_held = 1'b0;
        end
        while (cp_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_error_value(input logic [31:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        err_word = value;
    endtask

    // one beat per listed byte, stream end on the last one
    task automatic test_directed;
        logic [7:0] bytes [25] = '{
            8'h00, 8'h7F,                       // ascii extremes
            8'hC2, 8'h80,                       // smallest two-byte value
            8'hC0, 8'h80,                       // overlong two-byte form
            8'hED, 8'hA0, 8'h80,                // surrogate
            8'hEF, 8'hBF, 8'hBF,                // largest three-byte value
            8'hF4, 8'h90, 8'h80, 8'h80,         // above the scalar range
            8'hF0, 8'h90, 8'h80, 8'h80,         // smallest four-byte value
            8'hFF,                              // byte that cannot lead
            8'hC3, 8'h41,                       // broken continuation
            8'hE2, 8'h82                        // sequence cut short by the stream end
        };
        u8d_in_t beat;
        int      i;
        for (i = 0; i < 25; i++) begin
            beat.data_byte  = bytes[i];
            beat.stream_end = (i == 24);
            send_beat(beat);
        end
    endtask

    // a partial sequence must wait in the window while the sender holds off
    task automatic test_partial_hold;
        logic [7:0] bytes [6] = '{8'h41, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h0A};
        u8d_in_t beat;
        int      i;
        for (i = 0; i < 6; i++) begin
            if (i == 3) wait_idle();
            beat.data_byte  = bytes[i];
            beat.stream_end = (i == 5);
            send_beat(beat);
        end
    endtask

    // random text: mostly well-formed sequences, some malformed, cut or noisy
    task automatic test_random_text(input logic [31:0] err_value, input int n_bytes,
                                    input bit idling);
        int          sent;
        int          kind;
        int          len;
        int          r;
        int          i;
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] val;
        logic [7:0]  seq [4];
        u8d_in_t     beat;
        set_error_value(err_value);
        idle_on = idling;
        sent = 0;
        while (sent < n_bytes) begin
            kind = $urandom_range(0, 9);
            len  = (kind == 6 || kind == 9) ? $urandom_range(2, 4) : $urandom_range(1, 4);
            // value range for the chosen length, well-formed or malformed
            case (len)
                1: begin lo = 21'h0; hi = 21'h7F; end
                2: begin lo = 21'h80; hi = 21'h7FF; end
                3: begin lo = 21'h800; hi = 21'hFFFF; end
                default: begin lo = 21'h10000; hi = 21'h10FFFF; end
            endcase
            if (kind == 6) begin
                r = $urandom_range(0, 1);
                case (len)
                    2: begin lo = 21'h0; hi = 21'h7F; end
                    3: begin
                        lo = r ? 21'hD800 : 21'h0;
                        hi = r ? 21'hDFFF : 21'h7FF;
                    end
                    default: begin
                        lo = r ? 21'h110000 : 21'h0;
                        hi = r ? 21'h1FFFFF : 21'hFFFF;
                    end
                endcase
            end
            r = $urandom_range(0, 7);
            if (r == 0) val = lo;
            else if (r == 1) val = hi;
            else val = 21'($urandom_range(int'(lo), int'(hi)));
            // keep well-formed three-byte values clear of the surrogates
            if (kind != 6 && len == 3 && val >= 21'hD800 && val <= 21'hDFFF) begin
                val = val ^ 21'h2000;
            end
            case (len)
                1: seq[0] = {1'b0, val[6:0]};
                2: begin
                    seq[0] = {3'b110, val[10:6]};
                    seq[1] = {CONT_BITS, val[5:0]};
                end
                3: begin
                    seq[0] = {4'b1110, val[15:12]};
                    seq[1] = {CONT_BITS, val[11:6]};
                    seq[2] = {CONT_BITS, val[5:0]};
                end
                default: begin
                    seq[0] = {5'b11110, val[20:18]};
                    seq[1] = {CONT_BITS, val[17:12]};
                    seq[2] = {CONT_BITS, val[11:6]};
                    seq[3] = {CONT_BITS, val[5:0]};
                end
            endcase
            case (kind)
                7: if (len > 1) len = $urandom_range(1, len - 1);
                8: begin
                    seq[0] = 8'($urandom_range(0, 255));
                    len = 1;
                end
                9: seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
                default: ;
            endcase
            for (i = 0; i < len; i++) begin
                beat.data_byte  = seq[i];
                beat.stream_end = ($urandom_range(0, 11) == 0);
                send_beat(beat);
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    // result sink with random stalls
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare every accepted result beat with the oldest expected code point
    always @(posedge aclk) begin : result_check
        u8d_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cp_expected.size() == 0) begin
                flag_mismatch("unexpected beat", m_data.code_point, 32'd0);
            end else begin
                want = cp_expected.pop_front();
                if (m_data.code_point !== want.code_point)
                    flag_mismatch("code_point", m_data.code_point, want.code_point);
                if (m_data.valid_res !== want.valid_res)
                    flag_mismatch("valid_res", 32'(m_data.valid_res), 32'(want.valid_res));
                if (m_data.bytes_used !== want.bytes_used)
                    flag_mismatch("bytes_used", 32'(m_data.bytes_used), 32'(want.bytes_used));
                if (m_data.run_last !== want.run_last)
                    flag_mismatch("run_last", 32'(m_data.run_last), 32'(want.run_last));
                if (m_data.final_result !== want.final_result)
                    flag_mismatch("final_result", 32'(m_data.final_result),
                                  32'(want.final_result));
            end
        end
    end

    // test sequence
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_partial_hold();
        test_random_text(32'hFFFF_FFFF, 30, 1'b1);
        test_random_text(32'h0000_0000, 30, 1'b0);
        test_random_text($urandom, 30, 1'b1);
        test_random_text(ERR_AT_RESET, 30, 1'b1);
        wait_idle();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
